// ----- sv/parallel_port_nibble_mode_unit_macros.svh -----
// Assertion macros shared by the parallel port nibble-mode RTL.
`ifndef PARALLEL_PORT_NIBBLE_MODE_UNIT_MACROS_SVH
`define PARALLEL_PORT_NIBBLE_MODE_UNIT_MACROS_SVH
`ifndef SYNTH
// Checked while out of reset.
`define PPN_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Checked on every edge, reset included.
`define PPN_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define PPN_ASSERT(lbl, prop, msg)
`define PPN_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ----- sv/ppn_pkg.sv -----
// Shared constants, types and codes of the parallel port nibble-mode unit.
`default_nettype none
package ppn_pkg;

  localparam int unsigned FIFO_DEPTH_DEF = 256;

  // Item commands
  localparam logic [1:0] CMD_READ   = 2'd0;
  localparam logic [1:0] CMD_WRITE  = 2'd1;
  localparam logic [1:0] CMD_INJECT = 2'd2;

  // Register offsets
  localparam logic [2:0] OFF_DATA   = 3'd0;
  localparam logic [2:0] OFF_STATUS = 3'd1;
  localparam logic [2:0] OFF_CTRL   = 3'd2;

  // Control register bits
  localparam int unsigned C_STROBE = 0;
  localparam int unsigned C_AUTOFD = 1;
  localparam int unsigned C_SELIN  = 3;
  localparam int unsigned C_IRQEN  = 4;

  localparam logic [7:0] CONTROL_RESET = 8'h0C;
  localparam logic [7:0] STATUS_IDLE   = 8'hD8;

  // Status register bits
  localparam logic [7:0] S_IRQ    = 8'h04;
  localparam logic [7:0] S_ERROR  = 8'h08;
  localparam logic [7:0] S_SELECT = 8'h10;
  localparam logic [7:0] S_PAPER  = 8'h20;
  localparam logic [7:0] S_ACK    = 8'h40;
  localparam logic [7:0] S_BUSY   = 8'h80;

  typedef struct packed {
    logic       push;
    logic       pop;
    logic [7:0] wdata;
  } fifo_req_t;

  typedef struct packed {
    logic       empty;
    logic       full;
    logic [7:0] rdata;
  } fifo_rsp_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       fwd_valid;
    logic [7:0] fwd_data;
    logic       irq_raise;
    logic       inject_accepted;
  } result_t;

endpackage
`default_nettype wire

// ----- sv/ppn_if.sv -----
// Valid/ready channel interfaces for items and results.
`default_nettype none
interface ppn_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [2:0] offset;
  logic [7:0] write_data;

  modport source (output valid, command, offset, write_data, input ready);
  modport sink   (input valid, command, offset, write_data, output ready);
endinterface

interface ppn_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       fwd_valid;
  logic [7:0] fwd_data;
  logic       irq_raise;
  logic       inject_accepted;

  modport source (output valid, read_data, fwd_valid, fwd_data, irq_raise, inject_accepted,
                  input ready);
  modport sink   (input valid, read_data, fwd_valid, fwd_data, irq_raise, inject_accepted,
                  output ready);
endinterface
`default_nettype wire

// ----- sv/ppn_fifo.sv -----
// Reverse-channel byte FIFO: synchronous memory, wrap pointers, prefetch with bypass.
`default_nettype none
`include "parallel_port_nibble_mode_unit_macros.svh"
module ppn_fifo #(
  parameter int unsigned DEPTH = ppn_pkg::FIFO_DEPTH_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire ppn_pkg::fifo_req_t req_i,
  output      ppn_pkg::fifo_rsp_t rsp_o
);
  import ppn_pkg::*;

  localparam int unsigned SPAN = 2 * DEPTH;
  localparam int unsigned PW   = $clog2(SPAN);
  localparam int unsigned AW   = $clog2(DEPTH);

  logic [7:0]    mem [DEPTH];
  logic [PW-1:0] head_q, head_d, tail_q, tail_d;
  logic [AW-1:0] waddr, raddr;
  logic [7:0]    mem_rd_q, byp_data_q;
  logic          byp_hit_q;

  function automatic logic [PW-1:0] next_ptr(logic [PW-1:0] p);
    return (p == PW'(SPAN - 1)) ? '0 : p + 1'b1;
  endfunction

  // Pointers stay below twice the depth: one compare and subtract.
  function automatic logic [AW-1:0] slot(logic [PW-1:0] p);
    logic [PW-1:0] t;
    t = (p >= PW'(DEPTH)) ? p - PW'(DEPTH) : p;
    return t[AW-1:0];
  endfunction

  assign head_d = req_i.push ? next_ptr(head_q) : head_q;
  assign tail_d = req_i.pop  ? next_ptr(tail_q) : tail_q;
  assign waddr  = slot(head_q);
  assign raddr  = slot(tail_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q    <= '0;
      tail_q    <= '0;
      byp_hit_q <= 1'b0;
    end else begin
      head_q    <= head_d;
      tail_q    <= tail_d;
      byp_hit_q <= req_i.push && (waddr == raddr);
    end
  end

  // Head-of-queue entry is prefetched into a register; a same-entry write is bypassed.
  always_ff @(posedge clk_i) begin
    if (req_i.push) begin
      mem[waddr] <= req_i.wdata;
    end
    mem_rd_q   <= mem[raddr];
    byp_data_q <= req_i.wdata;
  end

  assign rsp_o.empty = (head_q == tail_q);
  assign rsp_o.full  = (head_q != tail_q) && (slot(head_q) == slot(tail_q));
  assign rsp_o.rdata = byp_hit_q ? byp_data_q : mem_rd_q;

  `PPN_ASSERT(a_pop_not_empty, req_i.pop |-> !rsp_o.empty, "pop from empty FIFO")
  `PPN_ASSERT(a_push_not_full, req_i.push |-> !rsp_o.full, "push into full FIFO")
  `PPN_ASSERT(a_push_fills, req_i.push |=> !rsp_o.empty, "FIFO empty after push")

endmodule
`default_nettype wire

// ----- sv/ppn_core.sv -----
// Register file, phase machine, status decode and interrupt latch.
`default_nettype none
`include "parallel_port_nibble_mode_unit_macros.svh"
module ppn_core (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               step_i,
  input  wire logic [1:0]         command_i,
  input  wire logic [2:0]         offset_i,
  input  wire logic [7:0]         write_data_i,
  input  wire ppn_pkg::fifo_rsp_t fifo_rsp_i,
  output      ppn_pkg::fifo_req_t fifo_req_o,
  output      ppn_pkg::result_t   result_o
);
  import ppn_pkg::*;

  localparam logic [2:0] PH_FWD     = 3'd0;
  localparam logic [2:0] PH_NEGOT   = 3'd1;
  localparam logic [2:0] PH_RIDLE   = 3'd2;
  localparam logic [2:0] PH_LO_DAV  = 3'd3;
  localparam logic [2:0] PH_LO_DONE = 3'd4;
  localparam logic [2:0] PH_HI_DAV  = 3'd5;

  logic [7:0] data_q, data_d, ctrl_q, ctrl_d, cur_q, cur_d;
  logic [2:0] phase_q, phase_d, ph;
  logic       curv_q, curv_d, irq_q, irq_d;
  logic       af_up, af_down, sel_up, strobe_up, term, fwd;

  function automatic logic [7:0] nibble_bits(logic [3:0] n);
    return {~n[3], 1'b0, n[2], n[1], n[0], 3'b000};
  endfunction

  function automatic logic ack_of(logic [2:0] p);
    logic a;
    unique case (p) inside
      PH_NEGOT, PH_LO_DAV, PH_HI_DAV: a = 1'b0;
      default:                        a = 1'b1;
    endcase
    return a;
  endfunction

  function automatic logic [7:0] status_of(logic [2:0] p, logic [7:0] cb, logic cv,
                                           logic empty, logic irq);
    logic [7:0] s;
    unique case (p)
      PH_FWD:     s = S_ERROR | S_SELECT | S_BUSY | S_ACK;
      PH_NEGOT:   s = S_ERROR | S_SELECT | S_PAPER | S_BUSY;
      PH_RIDLE:   s = S_SELECT | S_BUSY | S_ACK | ((empty && !cv) ? S_ERROR : 8'h00);
      PH_LO_DAV:  s = nibble_bits(cb[3:0]);
      PH_LO_DONE: s = nibble_bits(cb[3:0]) | S_ACK;
      PH_HI_DAV:  s = nibble_bits(cb[7:4]);
      default:    s = STATUS_IDLE;
    endcase
    return irq ? (s | S_IRQ) : s;
  endfunction

  assign af_up     = !ctrl_q[C_AUTOFD] &&  write_data_i[C_AUTOFD];
  assign af_down   =  ctrl_q[C_AUTOFD] && !write_data_i[C_AUTOFD];
  assign sel_up    = !ctrl_q[C_SELIN]  &&  write_data_i[C_SELIN];
  assign strobe_up = !ctrl_q[C_STROBE] &&  write_data_i[C_STROBE];

  always_comb begin
    data_d     = data_q;
    ctrl_d     = ctrl_q;
    phase_d    = phase_q;
    cur_d      = cur_q;
    curv_d     = curv_q;
    irq_d      = irq_q;
    ph         = phase_q;
    term       = 1'b0;
    fwd        = 1'b0;
    result_o   = '0;
    fifo_req_o = '0;
    fifo_req_o.wdata = write_data_i;

    if (step_i) begin
      unique case (command_i)
        CMD_READ: begin
          unique case (offset_i)
            OFF_DATA:   result_o.read_data = data_q;
            OFF_STATUS: begin
              result_o.read_data = status_of(phase_q, cur_q, curv_q, fifo_rsp_i.empty, irq_q);
              irq_d = 1'b0;
            end
            OFF_CTRL:   result_o.read_data = ctrl_q;
            default:    ;
          endcase
        end
        CMD_WRITE: begin
          if (offset_i == OFF_DATA) begin
            data_d = write_data_i;
          end else if (offset_i == OFF_CTRL) begin
            ctrl_d = write_data_i;
            if (phase_q == PH_FWD) begin
              fwd = strobe_up;
              if (af_up && ctrl_q[C_SELIN] && !write_data_i[C_SELIN] && data_q == 8'h00) begin
                ph = PH_NEGOT;
              end
            end else if (sel_up) begin
              // termination: back to forward, current byte dropped, no interrupt
              term   = 1'b1;
              ph     = PH_FWD;
              curv_d = 1'b0;
            end
            if (!term) begin
              unique case (ph)
                PH_NEGOT:   if (af_down) ph = PH_RIDLE;
                PH_RIDLE: begin
                  if (af_up) begin
                    if (curv_q) begin
                      ph = PH_LO_DAV;
                    end else if (!fifo_rsp_i.empty) begin
                      cur_d      = fifo_rsp_i.rdata;
                      curv_d     = 1'b1;
                      fifo_req_o.pop = 1'b1;
                      ph         = PH_LO_DAV;
                    end
                  end
                end
                PH_LO_DAV:  if (af_down) ph = PH_LO_DONE;
                PH_LO_DONE: if (af_up) ph = PH_HI_DAV;
                PH_HI_DAV: begin
                  if (af_down) begin
                    curv_d = 1'b0;
                    ph     = PH_RIDLE;
                  end
                end
                default: ;
              endcase
              if (!ack_of(phase_q) && ack_of(ph) && write_data_i[C_IRQEN]) begin
                irq_d              = 1'b1;
                result_o.irq_raise = 1'b1;
              end
            end
            phase_d = ph;
            if (fwd && ph == PH_FWD) begin
              result_o.fwd_valid = 1'b1;
              result_o.fwd_data  = data_q;
            end
          end
        end
        CMD_INJECT: begin
          if (!fifo_rsp_i.full) begin
            fifo_req_o.push          = 1'b1;
            result_o.inject_accepted = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_q  <= 8'h00;
      ctrl_q  <= CONTROL_RESET;
      phase_q <= PH_FWD;
      cur_q   <= 8'h00;
      curv_q  <= 1'b0;
      irq_q   <= 1'b0;
    end else begin
      data_q  <= data_d;
      ctrl_q  <= ctrl_d;
      phase_q <= phase_d;
      cur_q   <= cur_d;
      curv_q  <= curv_d;
      irq_q   <= irq_d;
    end
  end

  `PPN_ASSERT(a_fwd_in_fwd_phase, result_o.fwd_valid |=> phase_q == PH_FWD, "stray forward")
  `PPN_ASSERT(a_irq_latches, result_o.irq_raise |=> irq_q, "interrupt edge without latch")
  `PPN_ASSERT_ALWAYS(a_nib_byte, (phase_q >= PH_LO_DAV && phase_q <= PH_HI_DAV) |-> curv_q, "no byte")

endmodule
`default_nettype wire

// ----- sv/parallel_port_nibble_mode_unit.sv -----
// Top level of the parallel port with nibble-mode reverse channel.
`default_nettype none
// Standard parallel port (data, status, control) with an IEEE 1284 nibble-mode
// reverse channel. Each input transfer is a register read, a register write or
// a peripheral byte to queue; each one yields exactly one result transfer.
// An item is taken every cycle while the result register is free or being
// drained in the same cycle, and its result appears in the next cycle: all
// register, phase and status logic is combinational. Peripheral bytes
// sit in a FIFO_DEPTH-entry synchronous memory; the entry at the head of the
// queue is prefetched every cycle (a write to that same entry is bypassed), so
// a reverse-transfer start can load the current byte without a stall. The FIFO
// memory holds no reset state and needs no clearing pass; the block is ready
// from the first cycle after reset.
module parallel_port_nibble_mode_unit #(
  parameter int unsigned FIFO_DEPTH = ppn_pkg::FIFO_DEPTH_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  ppn_in_if.sink    in_i,
  ppn_out_if.source out_o
);
  import ppn_pkg::*;

  fifo_req_t fifo_req;
  fifo_rsp_t fifo_rsp;
  result_t   result;
  result_t   res_q;
  logic      out_valid_q;
  logic      step;

  // Result register frees up when empty or when its transfer completes now.
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign step       = in_i.valid && in_i.ready;

  ppn_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (step),
    .command_i    (in_i.command),
    .offset_i     (in_i.offset),
    .write_data_i (in_i.write_data),
    .fifo_rsp_i   (fifo_rsp),
    .fifo_req_o   (fifo_req),
    .result_o     (result)
  );

  ppn_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (fifo_req),
    .rsp_o  (fifo_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      out_valid_q <= in_i.valid;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= result;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.read_data       = res_q.read_data;
  assign out_o.fwd_valid       = res_q.fwd_valid;
  assign out_o.fwd_data        = res_q.fwd_data;
  assign out_o.irq_raise       = res_q.irq_raise;
  assign out_o.inject_accepted = res_q.inject_accepted;

endmodule
`default_nettype wire
